### design/assert_macros.svh
// Assertion macros used by the checker file of the event matcher.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds in the same cycle as its antecedent.
`define NEM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define NEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/nem_pkg.sv
// Package of the NFA event matcher: codes, state type and result record.
// Depends on nothing.
`default_nettype none
package nem_pkg;

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_EVENT   = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    localparam logic [1:0] KIND_SYMBOL = 2'd0;
    localparam logic [1:0] KIND_SPLIT  = 2'd1;
    localparam logic [1:0] KIND_MATCH  = 2'd2;
    localparam logic [1:0] KIND_DEAD   = 2'd3;

    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } nem_state_t;

    typedef struct packed {
        logic               matched;
        logic               at_start;
        logic [COUNT_W-1:0] active_count;
    } nem_res_t;

endpackage
`default_nettype wire

### design/nem_ifs.sv
// Handshake channels of the NFA event matcher: items, results, configuration.
// Depends on nothing.
`default_nettype none
interface nem_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [5:0] entry_index;
    logic [1:0] entry_kind;
    logic [7:0] entry_symbol;
    logic [6:0] entry_next;
    logic [6:0] entry_alt;
    logic [7:0] event_symbol;
    modport source (output valid, action, entry_index, entry_kind, entry_symbol,
                    entry_next, entry_alt, event_symbol, input ready);
    modport sink (input valid, action, entry_index, entry_kind, entry_symbol,
                  entry_next, entry_alt, event_symbol, output ready);
endinterface

interface nem_result_if;
    logic       valid;
    logic       ready;
    logic       matched;
    logic       at_start;
    logic [6:0] active_count;
    modport source (output valid, matched, at_start, active_count, input ready);
    modport sink (input valid, matched, at_start, active_count, output ready);
endinterface

interface nem_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] start_index;
    modport source (output valid, start_index, input ready);
    modport sink (input valid, start_index, output ready);
endinterface
`default_nettype wire

### design/nem_table.sv
// State table memory: one write port, one read port with registered data.
// Depends on nothing.
`default_nettype none
module nem_table #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 24,
    parameter int IDX_W = 6
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [IDX_W-1:0] raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### design/nem_engine.sv
// Closure engine: sweeps the state table, follows split arrows and builds the new set.
// Depends on nem_pkg; reads the table through nem_table's port.
`default_nettype none
module nem_engine #(
    parameter int MAX_STATES = 64,
    parameter int SYMBOL_BITS = 8,
    parameter int IDX_W = 6,
    parameter int ENT_W = 24
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic                   is_event,
    input  wire logic [SYMBOL_BITS-1:0] event_sym,
    input  wire logic [5:0]             start_index,
    output logic                        rd_en,
    output logic      [IDX_W-1:0]       rd_addr,
    input  wire logic [ENT_W-1:0]       rd_data,
    output logic                        busy,
    output logic                        res_valid,
    output nem_pkg::nem_res_t           res,
    input  wire logic                   res_ready
);

    localparam int CNT_W = $clog2(MAX_STATES + 1);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_STATES - 1);

    nem_pkg::nem_state_t state_reg, state_next;
    logic [IDX_W-1:0]       iss_reg, iss_next, pidx_reg, pidx_next;
    logic                   iss_on_reg, iss_on_next, pv_reg, pv_next;
    logic                   first_reg, first_next, again_reg, again_next;
    logic                   is_ev_reg, is_ev_next, match_reg, match_next;
    logic [SYMBOL_BITS-1:0] evs_reg, evs_next;
    logic [MAX_STATES-1:0]  active_reg, active_next, seen_reg, seen_next;
    logic [MAX_STATES-1:0]  pend_reg, pend_next, dst_reg, dst_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic [1:0]             e_kind;
    logic [SYMBOL_BITS-1:0] e_sym;
    logic [6:0]             e_next, e_alt;
    logic                   mark_a, mark_b, again_now;

    assign e_alt  = rd_data[6:0];
    assign e_next = rd_data[13:7];
    assign e_sym  = rd_data[14 +: SYMBOL_BITS];
    assign e_kind = rd_data[14 + SYMBOL_BITS +: 2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= nem_pkg::ST_IDLE;
            iss_on_reg <= 1'b0;
            pv_reg     <= 1'b0;
            active_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            iss_on_reg <= iss_on_next;
            pv_reg     <= pv_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_reg   <= iss_next;
        pidx_reg  <= pidx_next;
        first_reg <= first_next;
        again_reg <= again_next;
        is_ev_reg <= is_ev_next;
        evs_reg   <= evs_next;
        seen_reg  <= seen_next;
        pend_reg  <= pend_next;
        dst_reg   <= dst_next;
        cnt_reg   <= cnt_next;
        match_reg <= match_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        iss_next    = iss_reg;
        iss_on_next = iss_on_reg;
        pv_next     = 1'b0;
        pidx_next   = iss_reg;
        first_next  = first_reg;
        again_next  = again_reg;
        is_ev_next  = is_ev_reg;
        evs_next    = evs_reg;
        active_next = active_reg;
        seen_next   = seen_reg;
        pend_next   = pend_reg;
        dst_next    = dst_reg;
        cnt_next    = cnt_reg;
        match_next  = match_reg;
        mark_a      = 1'b0;
        mark_b      = 1'b0;
        again_now   = 1'b0;
        res_valid   = 1'b0;

        unique case (state_reg)
            nem_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next  = nem_pkg::ST_SWEEP;
                    iss_next    = '0;
                    iss_on_next = 1'b1;
                    first_next  = 1'b1;
                    again_next  = 1'b0;
                    is_ev_next  = is_event;
                    evs_next    = event_sym;
                    seen_next   = '0;
                    pend_next   = '0;
                    dst_next    = '0;
                    cnt_next    = '0;
                    match_next  = 1'b0;
                    if (int'(start_index) < MAX_STATES)
                    begin
                        seen_next[IDX_W'(start_index)] = 1'b1;
                        pend_next[IDX_W'(start_index)] = 1'b1;
                    end
                end
            end
            nem_pkg::ST_SWEEP:
            begin
                pv_next = iss_on_reg;
                if (iss_on_reg)
                begin
                    if (iss_reg == LAST)
                    begin
                        iss_on_next = 1'b0;
                    end
                    else
                    begin
                        iss_next = iss_reg + 1'b1;
                    end
                end
                if (pv_reg)
                begin
                    if (first_reg && is_ev_reg && active_reg[pidx_reg] &&
                        e_kind == nem_pkg::KIND_SYMBOL && e_sym == evs_reg)
                    begin
                        mark_a = 1'b1;
                    end
                    if (pend_reg[pidx_reg])
                    begin
                        pend_next[pidx_reg] = 1'b0;
                        if (e_kind == nem_pkg::KIND_SPLIT)
                        begin
                            mark_a = 1'b1;
                            mark_b = 1'b1;
                        end
                        else
                        begin
                            dst_next[pidx_reg] = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                            if (e_kind == nem_pkg::KIND_MATCH)
                            begin
                                match_next = 1'b1;
                            end
                        end
                    end
                    // A newly marked state at or behind the sweep needs another pass.
                    if (mark_a && int'(e_next) < MAX_STATES && !seen_reg[IDX_W'(e_next)])
                    begin
                        seen_next[IDX_W'(e_next)] = 1'b1;
                        pend_next[IDX_W'(e_next)] = 1'b1;
                        if (IDX_W'(e_next) <= pidx_reg)
                        begin
                            again_now = 1'b1;
                        end
                    end
                    if (mark_b && int'(e_alt) < MAX_STATES && !seen_reg[IDX_W'(e_alt)])
                    begin
                        seen_next[IDX_W'(e_alt)] = 1'b1;
                        pend_next[IDX_W'(e_alt)] = 1'b1;
                        if (IDX_W'(e_alt) <= pidx_reg)
                        begin
                            again_now = 1'b1;
                        end
                    end
                    again_next = again_reg | again_now;
                    if (pidx_reg == LAST)
                    begin
                        if (again_reg || again_now)
                        begin
                            iss_next    = '0;
                            iss_on_next = 1'b1;
                            first_next  = 1'b0;
                            again_next  = 1'b0;
                        end
                        else
                        begin
                            state_next = nem_pkg::ST_FINISH;
                        end
                    end
                end
            end
            nem_pkg::ST_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    active_next = dst_reg;
                    state_next  = nem_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nem_pkg::ST_IDLE;
            end
        endcase
    end

    assign rd_en   = iss_on_reg;
    assign rd_addr = iss_reg;
    assign busy    = (state_reg != nem_pkg::ST_IDLE);

    always_comb
    begin
        res.matched      = match_reg;
        res.at_start     = (cnt_reg == CNT_W'(1)) || ((cnt_reg == CNT_W'(2)) && match_reg);
        res.active_count = (int'(cnt_reg) > 127) ? 7'd127 : 7'(cnt_reg);
    end

endmodule
`default_nettype wire

### design/nfa_event_matcher.sv
// A load beat writes straight into the table; an event or restart beat offers its result
// once the engine has finished its sweeps of the state table.
// One beat at a time: no new beat is accepted until the engine is idle again.
// Reset (rst_n, asynchronous, active low) clears the active set, the start index
// and all handshake state; the state table holds garbage until loaded.
// Top level of the NFA event matcher; depends on nem_pkg, nem_ifs, nem_table, nem_engine.
`default_nettype none
module nfa_event_matcher #(
    parameter int MAX_STATES = 64,
    parameter int SYMBOL_BITS = 8
) (
    input wire logic     clk,
    input wire logic     rst_n,
    nem_item_if.sink     item,
    nem_result_if.source result,
    nem_cfg_if.sink      cfg
);

    localparam int IDX_W = $clog2(MAX_STATES);
    localparam int ENT_W = 16 + SYMBOL_BITS;

    // The start index register is written by its own channel, which never stalls.
    logic [5:0] start_reg;
    logic       item_acc, tbl_we, eng_start, eng_busy, eng_rd_en, eng_res_valid, eng_res_ready;
    logic       res_vld_reg;
    logic [IDX_W-1:0] eng_rd_addr;
    logic [ENT_W-1:0] tbl_rdata, tbl_wdata;
    nem_pkg::nem_res_t eng_res, res_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else if (cfg.valid)
        begin
            start_reg <= cfg.start_index;
        end
    end

    // Items are taken only while the engine is idle. A finished result may wait in the
    // output register, which frees the engine for one more beat; while that register is
    // still full, the engine holds its next result and the input stalls.
    assign item.ready = !eng_busy;
    assign item_acc   = item.valid && !eng_busy;

    // Loads go straight into the table; slots beyond the table are dropped.
    assign tbl_we    = item_acc && (item.action == nem_pkg::ACT_LOAD) &&
                       (int'(item.entry_index) < MAX_STATES);
    assign tbl_wdata = {item.entry_kind, item.entry_symbol[SYMBOL_BITS-1:0],
                        item.entry_next, item.entry_alt};

    // Unknown action codes fall through with no result.
    assign eng_start = item_acc && ((item.action == nem_pkg::ACT_EVENT) ||
                                    (item.action == nem_pkg::ACT_RESTART));

    nem_table #(
        .DEPTH (MAX_STATES),
        .WIDTH (ENT_W),
        .IDX_W (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (IDX_W'(item.entry_index)),
        .wdata (tbl_wdata),
        .re    (eng_rd_en),
        .raddr (eng_rd_addr),
        .rdata (tbl_rdata)
    );

    nem_engine #(
        .MAX_STATES  (MAX_STATES),
        .SYMBOL_BITS (SYMBOL_BITS),
        .IDX_W       (IDX_W),
        .ENT_W       (ENT_W)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (eng_start),
        .is_event    (item.action == nem_pkg::ACT_EVENT),
        .event_sym   (item.event_symbol[SYMBOL_BITS-1:0]),
        .start_index (start_reg),
        .rd_en       (eng_rd_en),
        .rd_addr     (eng_rd_addr),
        .rd_data     (tbl_rdata),
        .busy        (eng_busy),
        .res_valid   (eng_res_valid),
        .res         (eng_res),
        .res_ready   (eng_res_ready)
    );

    // Output register: the engine hands over its result when the register is free
    // or is being emptied in the same cycle.
    assign eng_res_ready = !res_vld_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (eng_res_valid && eng_res_ready)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_res_valid && eng_res_ready)
        begin
            res_reg <= eng_res;
        end
    end

    assign result.valid        = res_vld_reg;
    assign result.matched      = res_reg.matched;
    assign result.at_start     = res_reg.at_start;
    assign result.active_count = res_reg.active_count;

endmodule
`default_nettype wire

### design/nem_checker.sv
// Port-level checker for the NFA event matcher, bound to the top level.
// Depends on assert_macros.svh and the top level's interface ports.
`default_nettype none
`include "assert_macros.svh"
module nem_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       matched,
    input wire logic       at_start,
    input wire logic [6:0] active_count
);

    `NEM_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result beat dropped")
    `NEM_ASSERT_NOW(a_start_size, clk, rst_n, out_valid && at_start,
        active_count == 7'd1 || active_count == 7'd2, "start form with wrong size")
    `NEM_ASSERT_NOW(a_match_nonempty, clk, rst_n, out_valid && matched,
        active_count != 7'd0, "match reported on empty set")
    `NEM_ASSERT_NOW(a_pair_match, clk, rst_n, out_valid && at_start && active_count == 7'd2,
        matched, "two-state start form without match")

endmodule

bind nfa_event_matcher nem_checker u_nem_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .matched      (result.matched),
    .at_start     (result.at_start),
    .active_count (result.active_count)
);
`default_nettype wire
